FILE: rtl/core/lss_pkg.sv
// Shared types and codes for the byte stack with search.
// Used by the controller, the datapath and the top level; depends on nothing.
package lss_pkg;

   // Request operation codes
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   // Response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] popped_value;
      logic [4:0] position;
      logic [4:0] entry_count;
   } rsp_type;

   // Which response the datapath stages this cycle
   typedef enum logic [2:0] {
      RES_NONE,
      RES_PUSH_OK,
      RES_FULL,
      RES_EMPTY,
      RES_POP,
      RES_HIT,
      RES_MISS,
      RES_NOP
   } res_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        load;
      logic        push;
      logic        pop;
      logic        srch_start;
      logic        srch_step;
      res_sel_type res_sel;
      logic        emit;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       empty;
      logic       full;
      logic       match;
      logic       last;
      logic       out_free;
   } dp_sts_type;

endpackage

FILE: rtl/core/lss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module lss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, then registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lss_ctrl.sv
// Sequencer for the byte stack: accepts one request, steps the datapath
// through push, pop or search, and hands the result to the output register.
// Depends on lss_pkg.
module lss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lss_pkg::dp_sts_type sts,
   output lss_pkg::dp_cmd_type cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_EXEC  = 5'b00010,
      S_POPRD = 5'b00100,
      S_SRCH  = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_sel    = lss_pkg::RES_NONE;
      req_stall      = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_EMIT;
            unique case (sts.op)
               lss_pkg::OP_PUSH: begin
                  if (sts.full) begin
                     cmd.res_sel = lss_pkg::RES_FULL;
                  end else begin
                     cmd.push    = 1'b1;
                     cmd.res_sel = lss_pkg::RES_PUSH_OK;
                  end
               end
               lss_pkg::OP_POP: begin
                  if (sts.empty) begin
                     cmd.res_sel = lss_pkg::RES_EMPTY;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = S_POPRD;
                  end
               end
               lss_pkg::OP_SEARCH: begin
                  if (sts.empty) begin
                     cmd.res_sel = lss_pkg::RES_MISS;
                  end else begin
                     cmd.srch_start = 1'b1;
                     state_in       = S_SRCH;
                  end
               end
               default: begin
                  cmd.res_sel = lss_pkg::RES_NOP;
               end
            endcase
         end
         S_POPRD: begin
            cmd.res_sel = lss_pkg::RES_POP;
            state_in    = S_EMIT;
         end
         S_SRCH: begin
            // compare one entry per cycle, top down
            priority if (sts.match) begin
               cmd.res_sel = lss_pkg::RES_HIT;
               state_in    = S_EMIT;
            end else if (sts.last) begin
               cmd.res_sel = lss_pkg::RES_MISS;
               state_in    = S_EMIT;
            end else begin
               cmd.srch_step = 1'b1;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/lss_dp.sv
// Datapath of the byte stack: request latch, occupancy and search counters,
// entry RAM, comparator, staged result and output register.
// Depends on lss_pkg and lss_ram.
module lss_dp #(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  lss_pkg::req_type    req_payload,
   input  lss_pkg::dp_cmd_type cmd,
   output lss_pkg::dp_sts_type sts,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lss_pkg::rsp_type    rsp_payload
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [1:0]       op_ff;
   logic [7:0]       val_ff;
   logic [CW-1:0]    occ_ff, occ_in, occ_dec;
   logic [AW-1:0]    addr_ff, addr_in, top_addr, rd_addr;
   logic [CW-1:0]    d_ff, d_in;
   logic [7:0]       rd_data;
   lss_pkg::rsp_type res_ff, res_in;
   lss_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   assign occ_dec  = occ_ff - CW'(1);
   assign top_addr = occ_dec[AW-1:0];

   // Count and search pointers
   always_comb begin
      priority if (cmd.push) begin
         occ_in = occ_ff + CW'(1);
      end else if (cmd.pop) begin
         occ_in = occ_dec;
      end else begin
         occ_in = occ_ff;
      end

      priority if (cmd.srch_start) begin
         addr_in = top_addr;
         d_in    = CW'(1);
      end else if (cmd.srch_step) begin
         addr_in = addr_ff - AW'(1);
         d_in    = d_ff + CW'(1);
      end else begin
         addr_in = addr_ff;
         d_in    = d_ff;
      end

      priority if (cmd.pop) begin
         rd_addr = top_addr;
      end else begin
         rd_addr = addr_in;
      end
   end

   lss_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (occ_ff[AW-1:0]),
      .wr_data (val_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Stage the response chosen by the controller
   always_comb begin
      res_in             = res_ff;
      res_in.entry_count = 5'(occ_in);
      res_in.popped_value = '0;
      res_in.position    = '0;
      unique case (cmd.res_sel)
         lss_pkg::RES_PUSH_OK: res_in.status = lss_pkg::ST_OK;
         lss_pkg::RES_FULL:    res_in.status = lss_pkg::ST_FULL;
         lss_pkg::RES_EMPTY:   res_in.status = lss_pkg::ST_EMPTY;
         lss_pkg::RES_POP: begin
            res_in.status       = lss_pkg::ST_OK;
            res_in.popped_value = rd_data;
         end
         lss_pkg::RES_HIT: begin
            res_in.status   = lss_pkg::ST_OK;
            res_in.position = 5'(d_ff);
         end
         lss_pkg::RES_MISS:    res_in.status = lss_pkg::ST_NOT_FOUND;
         lss_pkg::RES_NOP:     res_in.status = lss_pkg::ST_OK;
         default:              res_in        = res_ff;
      endcase
   end

   // Output register: load on emit, drop when taken
   always_comb begin
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_payload.operation;
         val_ff <= req_payload.value;
      end
      addr_ff <= addr_in;
      d_ff    <= d_in;
      res_ff  <= res_in;
      if (cmd.emit) begin
         rsp_ff <= res_ff;
      end
   end

   // Status back to the controller
   assign sts.op       = op_ff;
   assign sts.empty    = (occ_ff == '0);
   assign sts.full     = (occ_ff == CW'(DEPTH));
   assign sts.match    = (rd_data == val_ff);
   assign sts.last     = (d_ff == occ_ff);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/core/lifo_stack_with_search_top.sv
// Bounded LIFO stack of bytes, DEPTH entries deep, with push, pop and a
// non-destructive search that reports the 1-based depth of the first match
// from the top. One request is handled at a time. Push, full push and the
// unused code pass through an execute and an emit state; pop adds a read
// state, and a search steps down until a match or the last entry: the
// entries sit in a RAM with one registered read port, so one entry is
// compared per cycle. A search on an empty stack is a miss without a RAM
// read. The result waits in an output register, so a new request can be
// accepted while the previous result is still stalled. Every result reports
// the entry count after the operation; position and entry_count keep their
// low 5 bits when DEPTH exceeds 31. Depends on lss_pkg, lss_ctrl, lss_dp.
module lifo_stack_with_search_top #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lss_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lss_pkg::rsp_type rsp_payload
);

   lss_pkg::dp_cmd_type cmd;
   lss_pkg::dp_sts_type sts;

   lss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lss_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTH
   // Busy right after a request is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a previous one was in flight");

   // Empty pop leaves nothing behind
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == lss_pkg::ST_EMPTY) |->
      (rsp_payload.entry_count == '0 && rsp_payload.popped_value == '0))
      else $error("empty pop reported data or entries");

   // A position comes only from a successful search
   a_position_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.position != '0) |->
      (rsp_payload.status == lss_pkg::ST_OK && rsp_payload.popped_value == '0))
      else $error("position reported outside a successful search");
`endif

endmodule
